// ----- rtl/hcrd_pkg.sv -----
// Shared types, constants and a helper function of the chunked response decoder.
`timescale 1ns / 1ps
`default_nettype none

package hcrd_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int LIMIT_WIDTH     = 32;
    localparam int STATUS_WIDTH    = 10;
    localparam int ERR_WIDTH       = 3;
    localparam int TE_LEN          = 26;
    localparam int TE_WIDTH        = 5;
    localparam int CRLF_WIDTH      = 3;
    localparam int OUT_DATA_WIDTH  = 24;

    localparam logic [STATUS_WIDTH-1:0] STATUS_MAX = 10'd999;

    localparam logic [ERR_WIDTH-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERR_WIDTH-1:0] ERR_NO_HEADER = 3'd1;
    localparam logic [ERR_WIDTH-1:0] ERR_LINE      = 3'd2;
    localparam logic [ERR_WIDTH-1:0] ERR_SIZE      = 3'd3;
    localparam logic [ERR_WIDTH-1:0] ERR_TERM      = 3'd4;
    localparam logic [ERR_WIDTH-1:0] ERR_TRUNC     = 3'd5;

    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_T     = 8'h74;

    // Byte classes worked out by the front end
    typedef struct packed {
        logic       is_cr;
        logic       is_lf;
        logic       is_space;
        logic       is_digit;
        logic       is_hex;
        logic [3:0] hex_val;
        logic [7:0] lc;
    } byte_class_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        byte_class_t cls;
    } item_t;

    // Lowercase pattern of the transfer-encoding header
    function automatic logic [7:0] te_char(input logic [TE_WIDTH-1:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = "t";
            5'd1:    c = "r";
            5'd2:    c = "a";
            5'd3:    c = "n";
            5'd4:    c = "s";
            5'd5:    c = "f";
            5'd6:    c = "e";
            5'd7:    c = "r";
            5'd8:    c = "-";
            5'd9:    c = "e";
            5'd10:   c = "n";
            5'd11:   c = "c";
            5'd12:   c = "o";
            5'd13:   c = "d";
            5'd14:   c = "i";
            5'd15:   c = "n";
            5'd16:   c = "g";
            5'd17:   c = ":";
            5'd18:   c = " ";
            5'd19:   c = "c";
            5'd20:   c = "h";
            5'd21:   c = "u";
            5'd22:   c = "n";
            5'd23:   c = "k";
            5'd24:   c = "e";
            5'd25:   c = "d";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/hcrd_front.sv -----
// Front end: takes input requests and classifies each raw byte for the decoder.
`timescale 1ns / 1ps
`default_nettype none

module hcrd_front
(
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire logic [7:0]     s_axis_tdata,
    input  wire logic           s_axis_tlast,
    input  wire logic           q_full,
    output logic                q_push,
    output hcrd_pkg::item_t     q_item
);

    logic [7:0]            b;
    hcrd_pkg::byte_class_t cls;

    assign b = s_axis_tdata;

    always_comb
    begin
        cls          = '0;
        cls.is_cr    = (b == hcrd_pkg::CHAR_CR);
        cls.is_lf    = (b == hcrd_pkg::CHAR_LF);
        cls.is_space = (b == hcrd_pkg::CHAR_SPACE);
        cls.is_digit = (b inside {["0":"9"]});
        cls.lc       = (b inside {["A":"Z"]}) ? b + 8'd32 : b;
        if (b inside {["0":"9"]})
        begin
            cls.is_hex  = 1'b1;
            cls.hex_val = b[3:0];
        end
        else if (b inside {["a":"f"], ["A":"F"]})
        begin
            // letters a..f sit at low nibble 1..6 in either case
            cls.is_hex  = 1'b1;
            cls.hex_val = b[3:0] + 4'd9;
        end
    end

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    always_comb
    begin
        q_item      = '0;
        q_item.data = b;
        q_item.last = s_axis_tlast;
        q_item.cls  = cls;
    end

endmodule

`default_nettype wire

// ----- rtl/hcrd_queue.sv -----
// Two-entry queue between the classifying front end and the decoder back end.
`timescale 1ns / 1ps
`default_nettype none

module hcrd_queue
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire hcrd_pkg::item_t push_item,
    output logic                 full,
    input  wire logic            pop,
    output logic                 not_empty,
    output hcrd_pkg::item_t      head
);

    hcrd_pkg::item_t entry_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            do_push, do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hcrd_core.sv -----
// Back end: header scan, chunk decoding and the registered result stage.
`timescale 1ns / 1ps
`default_nettype none

module hcrd_core
#(
    parameter int COUNT_WIDTH = hcrd_pkg::COUNT_WIDTH_DEF
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [hcrd_pkg::LIMIT_WIDTH-1:0]     cfg_wdata,
    input  wire logic                                 q_not_empty,
    input  wire hcrd_pkg::item_t                      q_head,
    output logic                                      q_pop,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [hcrd_pkg::OUT_DATA_WIDTH-1:0]       m_axis_tdata,
    output logic                                      m_axis_tuser
);

    localparam int CW   = COUNT_WIDTH;
    localparam int LW   = hcrd_pkg::LIMIT_WIDTH;
    localparam int CMPW = (CW > LW) ? CW : LW;
    localparam int SW   = hcrd_pkg::STATUS_WIDTH;
    localparam int EW   = hcrd_pkg::ERR_WIDTH;
    localparam int TW   = hcrd_pkg::TE_WIDTH;
    localparam int RW   = hcrd_pkg::CRLF_WIDTH;

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_LEN     = 3'd1;
    localparam logic [2:0] PH_LEN_LF  = 3'd2;
    localparam logic [2:0] PH_DATA    = 3'd3;
    localparam logic [2:0] PH_TERM_CR = 3'd4;
    localparam logic [2:0] PH_TERM_LF = 3'd5;
    localparam logic [2:0] PH_PLAIN   = 3'd6;
    localparam logic [2:0] PH_HALT    = 3'd7;

    localparam logic [1:0] SP_WAIT  = 2'd0;
    localparam logic [1:0] SP_SPACE = 2'd1;
    localparam logic [1:0] SP_DIGIT = 2'd2;
    localparam logic [1:0] SP_DONE  = 2'd3;

    localparam logic [RW-1:0] CRLF_DONE = 3'd4;

    logic [LW-1:0] limit_reg;
    logic [LW-1:0] room_reg, room_next;

    logic [2:0]    phase_reg, phase_next;
    logic [RW-1:0] crlf_reg, crlf_next;
    logic [TW-1:0] te_reg, te_next;
    logic [1:0]    sphase_reg, sphase_next;
    logic [SW-1:0] status_reg, status_next;
    logic          chunked_reg, chunked_next;
    logic [CW-1:0] chunk_reg, chunk_next;
    logic          hex_seen_reg, hex_seen_next;
    logic [CW-1:0] count_reg, count_next;
    logic [EW-1:0] err_reg, err_next;

    logic          out_valid_reg;
    logic          body_valid_reg, body_valid_next;
    logic [7:0]    body_byte_reg, body_byte_next;
    logic          fin_reg, fin_next;
    logic [SW-1:0] out_status_reg;
    logic          out_chunked_reg;
    logic [EW-1:0] out_err_reg;

    logic [CMPW-1:0] used_wide;
    logic [LW-1:0]   used;

    assign q_pop = q_not_empty && (!out_valid_reg || m_axis_tready);

    // Room left under the limit; body_count is stable for several bytes before
    // any length line completes, so a registered copy is current when read.
    always_comb
    begin
        used_wide = (CMPW'(count_reg) < CMPW'(limit_reg)) ? CMPW'(count_reg)
                                                          : CMPW'(limit_reg);
        used      = used_wide[LW-1:0];
        room_next = limit_reg - used;
    end

    always_comb
    begin
        logic [7:0]    b;
        logic          last;
        logic [RW-1:0] crlf_new;
        logic [13:0]   sv;
        logic          trip;
        logic [EW-1:0] trip_code;

        b         = q_head.data;
        last      = q_head.last;
        crlf_new  = '0;
        sv        = '0;
        trip      = 1'b0;
        trip_code = hcrd_pkg::ERR_NONE;

        phase_next      = phase_reg;
        crlf_next       = crlf_reg;
        te_next         = te_reg;
        sphase_next     = sphase_reg;
        status_next     = status_reg;
        chunked_next    = chunked_reg;
        chunk_next      = chunk_reg;
        hex_seen_next   = hex_seen_reg;
        count_next      = count_reg;
        err_next        = err_reg;
        body_valid_next = 1'b0;
        body_byte_next  = 8'd0;
        fin_next        = 1'b0;

        case (phase_reg)
            PH_HEADER:
            begin
                // status digits after the first space
                case (sphase_reg)
                    SP_WAIT:
                    begin
                        if (q_head.cls.is_space)
                        begin
                            sphase_next = SP_SPACE;
                        end
                    end
                    SP_SPACE, SP_DIGIT:
                    begin
                        if (q_head.cls.is_digit)
                        begin
                            sv = 14'(status_reg) * 14'd10 + 14'(b[3:0]);
                            status_next = (sv > 14'(hcrd_pkg::STATUS_MAX))
                                        ? hcrd_pkg::STATUS_MAX : sv[SW-1:0];
                            sphase_next = SP_DIGIT;
                        end
                        else if (!(sphase_reg == SP_SPACE && q_head.cls.is_space))
                        begin
                            sphase_next = SP_DONE;
                        end
                    end
                    default:
                    begin
                        sphase_next = sphase_reg;
                    end
                endcase

                if (!chunked_reg)
                begin
                    if (te_reg < TW'(hcrd_pkg::TE_LEN) &&
                        q_head.cls.lc == hcrd_pkg::te_char(te_reg))
                    begin
                        te_next = te_reg + 1'b1;
                    end
                    else
                    begin
                        te_next = (q_head.cls.lc == hcrd_pkg::CHAR_T) ? TW'(1) : TW'(0);
                    end
                    if (te_next == TW'(hcrd_pkg::TE_LEN))
                    begin
                        chunked_next = 1'b1;
                    end
                end

                if ((crlf_reg == 3'd0 || crlf_reg == 3'd2) && q_head.cls.is_cr)
                begin
                    crlf_new = crlf_reg + 1'b1;
                end
                else if ((crlf_reg == 3'd1 || crlf_reg == 3'd3) && q_head.cls.is_lf)
                begin
                    crlf_new = crlf_reg + 1'b1;
                end
                else
                begin
                    crlf_new = q_head.cls.is_cr ? RW'(1) : RW'(0);
                end

                if (crlf_new == CRLF_DONE)
                begin
                    crlf_next = '0;
                    if (chunked_next)
                    begin
                        phase_next    = PH_LEN;
                        hex_seen_next = 1'b0;
                        chunk_next    = '0;
                        if (last)
                        begin
                            trip      = 1'b1;
                            trip_code = hcrd_pkg::ERR_TRUNC;
                        end
                    end
                    else
                    begin
                        phase_next = PH_PLAIN;
                        fin_next   = last;
                    end
                end
                else
                begin
                    crlf_next = crlf_new;
                    if (last)
                    begin
                        trip      = 1'b1;
                        trip_code = hcrd_pkg::ERR_NO_HEADER;
                    end
                end
            end
            PH_LEN:
            begin
                if (q_head.cls.is_hex)
                begin
                    // saturate once the next shift would overflow
                    if (chunk_reg[CW-1 -: 4] != 4'd0)
                    begin
                        chunk_next = '1;
                    end
                    else
                    begin
                        chunk_next = {chunk_reg[CW-5:0], q_head.cls.hex_val};
                    end
                    hex_seen_next = 1'b1;
                    if (last)
                    begin
                        trip      = 1'b1;
                        trip_code = hcrd_pkg::ERR_LINE;
                    end
                end
                else if (q_head.cls.is_cr)
                begin
                    phase_next = PH_LEN_LF;
                    if (last)
                    begin
                        trip      = 1'b1;
                        trip_code = hcrd_pkg::ERR_LINE;
                    end
                end
                else
                begin
                    trip      = 1'b1;
                    trip_code = hcrd_pkg::ERR_LINE;
                end
            end
            PH_LEN_LF:
            begin
                if (q_head.cls.is_lf && hex_seen_reg)
                begin
                    if (chunk_reg == '0)
                    begin
                        phase_next = PH_HALT;
                    end
                    else if (chunk_reg == '1 || CMPW'(chunk_reg) > CMPW'(room_reg))
                    begin
                        trip      = 1'b1;
                        trip_code = hcrd_pkg::ERR_SIZE;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                        if (last)
                        begin
                            trip      = 1'b1;
                            trip_code = hcrd_pkg::ERR_SIZE;
                        end
                    end
                end
                else
                begin
                    trip      = 1'b1;
                    trip_code = hcrd_pkg::ERR_LINE;
                end
            end
            PH_DATA:
            begin
                body_valid_next = 1'b1;
                body_byte_next  = b;
                if (count_reg != '1)
                begin
                    count_next = count_reg + 1'b1;
                end
                chunk_next = chunk_reg - 1'b1;
                if (chunk_reg == CW'(1))
                begin
                    phase_next = PH_TERM_CR;
                end
                if (last)
                begin
                    trip      = 1'b1;
                    trip_code = (chunk_reg != CW'(1)) ? hcrd_pkg::ERR_SIZE
                                                      : hcrd_pkg::ERR_TERM;
                end
            end
            PH_TERM_CR:
            begin
                phase_next = PH_TERM_LF;
                if (!q_head.cls.is_cr || last)
                begin
                    trip      = 1'b1;
                    trip_code = hcrd_pkg::ERR_TERM;
                end
            end
            PH_TERM_LF:
            begin
                if (q_head.cls.is_lf)
                begin
                    phase_next    = PH_LEN;
                    hex_seen_next = 1'b0;
                    chunk_next    = '0;
                    if (last)
                    begin
                        trip      = 1'b1;
                        trip_code = hcrd_pkg::ERR_TRUNC;
                    end
                end
                else
                begin
                    trip      = 1'b1;
                    trip_code = hcrd_pkg::ERR_TERM;
                end
            end
            PH_PLAIN:
            begin
                body_valid_next = 1'b1;
                body_byte_next  = b;
                fin_next        = last;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        if (trip)
        begin
            err_next   = trip_code;
            phase_next = PH_HALT;
        end

        if (phase_next == PH_HALT && err_next == hcrd_pkg::ERR_NONE)
        begin
            fin_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= '1;
            phase_reg     <= PH_HEADER;
            crlf_reg      <= '0;
            te_reg        <= '0;
            sphase_reg    <= SP_WAIT;
            status_reg    <= '0;
            chunked_reg   <= 1'b0;
            chunk_reg     <= '0;
            hex_seen_reg  <= 1'b0;
            count_reg     <= '0;
            err_reg       <= hcrd_pkg::ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
                if (q_head.last)
                begin
                    // end of response: start the next one from scratch
                    phase_reg    <= PH_HEADER;
                    crlf_reg     <= '0;
                    te_reg       <= '0;
                    sphase_reg   <= SP_WAIT;
                    status_reg   <= '0;
                    chunked_reg  <= 1'b0;
                    chunk_reg    <= '0;
                    hex_seen_reg <= 1'b0;
                    count_reg    <= '0;
                    err_reg      <= hcrd_pkg::ERR_NONE;
                end
                else
                begin
                    phase_reg    <= phase_next;
                    crlf_reg     <= crlf_next;
                    te_reg       <= te_next;
                    sphase_reg   <= sphase_next;
                    status_reg   <= status_next;
                    chunked_reg  <= chunked_next;
                    chunk_reg    <= chunk_next;
                    hex_seen_reg <= hex_seen_next;
                    count_reg    <= count_next;
                    err_reg      <= err_next;
                end
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        room_reg <= room_next;
        if (q_pop)
        begin
            body_valid_reg  <= body_valid_next;
            body_byte_reg   <= body_byte_next;
            fin_reg         <= fin_next;
            out_status_reg  <= status_next;
            out_chunked_reg <= chunked_next;
            out_err_reg     <= err_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = body_valid_reg;
    assign m_axis_tdata  = {1'b0, out_err_reg, fin_reg, out_chunked_reg,
                            out_status_reg, body_byte_reg};

endmodule

`default_nettype wire

// ----- rtl/http_chunked_response_decoder_unit.sv -----
// Top level of the HTTP/1.1 response decoder with chunked body decoding.
// Path: each accepted byte goes through the queue into the result register.
// Throughput: one byte per cycle while results are taken; the two-entry queue
//   and result register take bytes while a result waits, until the queue fills.
// Reset: rst_n clears the stream state and sets body_limit to all ones.
// A byte marked last returns the stream state to reset after its result.
`timescale 1ns / 1ps
`default_nettype none

module http_chunked_response_decoder_unit
#(
    parameter int COUNT_WIDTH = hcrd_pkg::COUNT_WIDTH_DEF
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [hcrd_pkg::LIMIT_WIDTH-1:0]    cfg_wdata,     // body_limit
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [7:0]                          s_axis_tdata,  // in_byte
    input  wire logic                                s_axis_tlast,  // in_last
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // body_byte[7:0], http_status[17:8], is_chunked[18], finished[19],
    // error_code[22:20], zero[23]
    output logic [hcrd_pkg::OUT_DATA_WIDTH-1:0]      m_axis_tdata,
    output logic                                     m_axis_tuser   // body_valid
);

    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_not_empty;
    hcrd_pkg::item_t q_in;
    hcrd_pkg::item_t q_head;

    hcrd_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (q_in)
    );

    hcrd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    hcrd_core
    #(
        .COUNT_WIDTH (COUNT_WIDTH)
    )
    u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .q_not_empty   (q_not_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ----- rtl/hcrd_checker.sv -----
// Port-level checks of the decoder's result stream, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module hcrd_checker
(
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                m_axis_tvalid,
    input wire logic                                m_axis_tready,
    input wire logic [hcrd_pkg::OUT_DATA_WIDTH-1:0] m_axis_tdata,
    input wire logic                                m_axis_tuser
);

    // hold a stalled result
    ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // drop the body byte to zero when no body byte is carried
    ap_no_stray_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[7:0] == 8'd0)
        else $error("body byte set without body_valid");

    ap_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[17:8] <= hcrd_pkg::STATUS_MAX
                          && m_axis_tdata[22:20] <= hcrd_pkg::ERR_TRUNC)
        else $error("status or error code out of range");

    ap_fin_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[19] |-> m_axis_tdata[22:20] == hcrd_pkg::ERR_NONE)
        else $error("finished reported together with an error");

endmodule

bind http_chunked_response_decoder_unit hcrd_checker u_hcrd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ----- sim/hcrd_response_checker.sv -----
// Checker for the chunked response decoder: predicts each result and compares it.
`timescale 1ns / 1ps

module hcrd_response_checker
    import hcrd_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [LIMIT_WIDTH-1:0]    cfg_wdata,
    input  wire logic                      s_tvalid,
    input  wire logic                      s_tready,
    input  wire logic [7:0]                s_tdata,
    input  wire logic                      s_tlast,
    input  wire logic                      m_tvalid,
    input  wire logic                      m_tready,
    input  wire logic [OUT_DATA_WIDTH-1:0] m_tdata,
    input  wire logic                      m_tuser,
    output int unsigned                    outstanding,
    output int unsigned                    fail_count
);

    localparam logic [31:0] COUNT_ALL = 32'hFFFF_FFFF;
    localparam int HDR_LEN = 26;
    localparam logic [8*HDR_LEN-1:0] HDR_PATTERN = "transfer-encoding: chunked";
    localparam int unsigned MAX_PRINTED = 100;

    typedef enum logic [2:0] {
        DEC_HEADER,
        DEC_LEN,
        DEC_LEN_LF,
        DEC_DATA,
        DEC_TERM_CR,
        DEC_TERM_LF,
        DEC_PLAIN,
        DEC_HALT
    } dec_phase_e;

    typedef enum logic [1:0] {
        ST_WAIT_SPACE,
        ST_LEAD,
        ST_DIGITS,
        ST_DONE
    } status_phase_e;

    typedef struct packed {
        logic                    body_valid;
        logic [7:0]              body_byte;
        logic [STATUS_WIDTH-1:0] http_status;
        logic                    is_chunked;
        logic                    finished;
        logic [ERR_WIDTH-1:0]    error_code;
    } decode_result_t;

    decode_result_t       expected_q[$];
    decode_result_t       want;
    dec_phase_e           phase;
    status_phase_e        stat_phase;
    int unsigned          crlf_seen;
    int unsigned          te_seen;
    int unsigned          status_val;
    logic                 chunked;
    logic                 hex_seen;
    logic [31:0]          chunk_left;
    logic [31:0]          body_count;
    logic [31:0]          body_limit;
    logic [ERR_WIDTH-1:0] err_latch;

    function automatic void clear_stream();
        phase      = DEC_HEADER;
        stat_phase = ST_WAIT_SPACE;
        crlf_seen  = 0;
        te_seen    = 0;
        status_val = 0;
        chunked    = 1'b0;
        hex_seen   = 1'b0;
        chunk_left = '0;
        body_count = '0;
        err_latch  = ERR_NONE;
    endfunction

    function automatic void halt_on(input logic [ERR_WIDTH-1:0] code);
        err_latch = code;
        phase     = DEC_HALT;
    endfunction

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic void scan_header_byte(input logic [7:0] b);
        logic [7:0]  lc;
        int unsigned v;
        lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;

        case (stat_phase)
            ST_WAIT_SPACE:
                if (b == CHAR_SPACE)
                    stat_phase = ST_LEAD;
            ST_LEAD, ST_DIGITS:
                if (b >= "0" && b <= "9")
                begin
                    v          = status_val * 10 + int'(b - "0");
                    status_val = (v > 999) ? 999 : v;
                    stat_phase = ST_DIGITS;
                end
                else if (!(stat_phase == ST_LEAD && b == CHAR_SPACE))
                begin
                    stat_phase = ST_DONE;
                end
            default:
                ;
        endcase

        // restart the pattern match on any miss, keeping a fresh 't'
        if (!chunked)
        begin
            if (te_seen < HDR_LEN && lc == HDR_PATTERN[8*(HDR_LEN-1-te_seen) +: 8])
                te_seen++;
            else
                te_seen = (lc == CHAR_T) ? 1 : 0;
            if (te_seen == HDR_LEN)
                chunked = 1'b1;
        end

        if ((crlf_seen == 0 || crlf_seen == 2) && b == CHAR_CR)
            crlf_seen++;
        else if ((crlf_seen == 1 || crlf_seen == 3) && b == CHAR_LF)
            crlf_seen++;
        else
            crlf_seen = (b == CHAR_CR) ? 1 : 0;
    endfunction

    function automatic decode_result_t decode_byte(input logic [7:0] b, input logic last);
        decode_result_t r;
        int             d;
        logic [31:0]    room;
        r = '0;

        case (phase)
            DEC_HEADER:
            begin
                scan_header_byte(b);
                if (crlf_seen == 4)
                begin
                    crlf_seen = 0;
                    if (chunked)
                    begin
                        phase      = DEC_LEN;
                        hex_seen   = 1'b0;
                        chunk_left = '0;
                        if (last)
                            halt_on(ERR_TRUNC);
                    end
                    else
                    begin
                        phase = DEC_PLAIN;
                        if (last)
                            r.finished = 1'b1;
                    end
                end
                else if (last)
                begin
                    halt_on(ERR_NO_HEADER);
                end
            end
            DEC_LEN:
            begin
                d = hex_digit(b);
                if (d >= 0)
                begin
                    // saturate the length instead of wrapping
                    if (chunk_left > (COUNT_ALL >> 4))
                        chunk_left = COUNT_ALL;
                    else
                        chunk_left = {chunk_left[27:0], 4'(d)};
                    hex_seen = 1'b1;
                    if (last)
                        halt_on(ERR_LINE);
                end
                else if (b == CHAR_CR)
                begin
                    phase = DEC_LEN_LF;
                    if (last)
                        halt_on(ERR_LINE);
                end
                else
                begin
                    halt_on(ERR_LINE);
                end
            end
            DEC_LEN_LF:
            begin
                if (b == CHAR_LF && hex_seen)
                begin
                    room = body_limit - ((body_count < body_limit) ? body_count : body_limit);
                    if (chunk_left == '0)
                        phase = DEC_HALT;
                    else if (chunk_left == COUNT_ALL || chunk_left > room)
                        halt_on(ERR_SIZE);
                    else
                    begin
                        phase = DEC_DATA;
                        if (last)
                            halt_on(ERR_SIZE);
                    end
                end
                else
                begin
                    halt_on(ERR_LINE);
                end
            end
            DEC_DATA:
            begin
                r.body_valid = 1'b1;
                r.body_byte  = b;
                if (body_count != COUNT_ALL)
                    body_count++;
                chunk_left--;
                if (chunk_left == '0)
                    phase = DEC_TERM_CR;
                if (last)
                    halt_on((chunk_left != '0) ? ERR_SIZE : ERR_TERM);
            end
            DEC_TERM_CR:
            begin
                if (b == CHAR_CR)
                begin
                    phase = DEC_TERM_LF;
                    if (last)
                        halt_on(ERR_TERM);
                end
                else
                begin
                    halt_on(ERR_TERM);
                end
            end
            DEC_TERM_LF:
            begin
                if (b == CHAR_LF)
                begin
                    phase      = DEC_LEN;
                    hex_seen   = 1'b0;
                    chunk_left = '0;
                    if (last)
                        halt_on(ERR_TRUNC);
                end
                else
                begin
                    halt_on(ERR_TERM);
                end
            end
            DEC_PLAIN:
            begin
                r.body_valid = 1'b1;
                r.body_byte  = b;
                if (last)
                    r.finished = 1'b1;
            end
            default:
                ;
        endcase

        if (phase == DEC_HALT && err_latch == ERR_NONE)
            r.finished = 1'b1;
        r.http_status = STATUS_WIDTH'(status_val);
        r.is_chunked  = chunked;
        r.error_code  = err_latch;

        if (last)
            clear_stream();
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        if (fail_count < MAX_PRINTED)
            $display("mismatch at %0t ns: %s got 0x%0h, expected 0x%0h",
                     $time, what, got, exp_val);
        fail_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch(what, got, exp_val);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_limit = '1;
            clear_stream();
            expected_q.delete();
            fail_count  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
                body_limit = cfg_wdata;

            if (s_tvalid && s_tready)
                expected_q.push_back(decode_byte(s_tdata, s_tlast));

            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    report_mismatch("result with no request pending", 32'(m_tdata), 0);
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("body_valid",  32'(m_tuser),         32'(want.body_valid));
                    check_field("body_byte",   32'(m_tdata[7:0]),    32'(want.body_byte));
                    check_field("http_status", 32'(m_tdata[17:8]),   32'(want.http_status));
                    check_field("is_chunked",  32'(m_tdata[18]),     32'(want.is_chunked));
                    check_field("finished",    32'(m_tdata[19]),     32'(want.finished));
                    check_field("error_code",  32'(m_tdata[22:20]),  32'(want.error_code));
                    check_field("pad bit",     32'(m_tdata[23]),     0);
                end
            end

            outstanding <= expected_q.size();
        end
    end

endmodule

// ----- sim/http_chunked_response_decoder_unit_tb.sv -----
// Testbench top for the chunked response decoder: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module http_chunked_response_decoder_unit_tb;
    import hcrd_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned PHASE_BYTES  = 40;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [LIMIT_WIDTH-1:0]    cfg_wdata = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [7:0]                s_axis_tdata = '0;
    logic                      s_axis_tlast = 1'b0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_DATA_WIDTH-1:0] m_axis_tdata;
    logic                      m_axis_tuser;

    int unsigned outstanding;
    int unsigned fail_count;
    int unsigned cycle_count = 0;
    int unsigned sent_bytes = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned send_idle_by_phase[4] = '{0, 70, 0, 20};
    int unsigned recv_stall_by_phase[4] = '{0, 0, 70, 20};

    string other_headers[5] = '{
        "Host: h",
        "Transfer-Encoding: gzip",
        "Content-Length: 7",
        "transfer-encoding:chunked",
        "transfer-encoding: chunk"
    };
    logic [7:0] odd_bytes[4] = '{CHAR_CR, CHAR_LF, CHAR_SPACE, "g"};

    // bytes of the response being assembled
    logic [7:0] resp_q[$];

    http_chunked_response_decoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    hcrd_response_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_axis_tvalid),
        .s_tready    (s_axis_tready),
        .s_tdata     (s_axis_tdata),
        .s_tlast     (s_axis_tlast),
        .m_tvalid    (m_axis_tvalid),
        .m_tready    (m_axis_tready),
        .m_tdata     (m_axis_tdata),
        .m_tuser     (m_axis_tuser),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    always #5ns clk = ~clk;

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic add_byte(input logic [7:0] b);
        resp_q.push_back(b);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            resp_q.push_back(s[i]);
    endtask

    task automatic add_crlf();
        add_byte(CHAR_CR);
        add_byte(CHAR_LF);
    endtask

    task automatic add_mixed_case(input string s);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++)
        begin
            c = s[i];
            if (c >= "a" && c <= "z" && $urandom_range(1) == 1)
                c = c - 8'd32;
            resp_q.push_back(c);
        end
    endtask

    task automatic add_chunked_head();
        add_text("HTTP/1.1 200");
        add_crlf();
        add_text("transfer-encoding: chunked");
        add_crlf();
        add_crlf();
    endtask

    // hold the request until accepted, idling the sender at random first
    task automatic push_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= is_last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent_bytes++;
    endtask

    task automatic send_response();
        int n;
        n = resp_q.size();
        for (int i = 0; i < n; i++)
            push_byte(resp_q[i], i == n - 1);
        resp_q.delete();
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_WIDTH-1:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [LIMIT_WIDTH-1:0] random_limit();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(1, 30);
            default: return $urandom();
        endcase
    endfunction

    task automatic add_status_line();
        int pick;
        pick = $urandom_range(9);
        add_text("HTTP/1.1");
        if (pick != 0)
        begin
            if (pick < 3)
                add_text("  ");
            else
                add_text(" ");
            add_text($sformatf("%0d", $urandom_range((pick < 6) ? 999 : 99999)));
            if ($urandom_range(1) == 1)
                add_text(" OK");
        end
        add_crlf();
    endtask

    task automatic add_other_headers();
        repeat ($urandom_range(2))
        begin
            add_text(other_headers[$urandom_range(4)]);
            add_crlf();
        end
    endtask

    task automatic add_chunks();
        int pick;
        int len;
        for (int k = 0; k < $urandom_range(3); k++)
        begin
            pick = $urandom_range(19);
            if (pick == 19)
            begin
                // oversized length: saturates or hits the all-ones value
                if ($urandom_range(1) == 1)
                    add_mixed_case("ffffffff");
                else
                    add_mixed_case("fedcba987");
                add_crlf();
                add_byte($urandom_range(255));
                break;
            end
            len = (pick < 15) ? $urandom_range(1, 8) : $urandom_range(9, 40);
            if ($urandom_range(3) == 0)
                add_text("0");
            add_mixed_case($sformatf("%0h", len));
            add_crlf();
            repeat (len) add_byte($urandom_range(255));
            add_crlf();
        end
        if ($urandom_range(1) == 1)
            add_text("0");
        else
            add_text("00");
        add_crlf();
        if ($urandom_range(1) == 1)
            add_crlf();
    endtask

    task automatic build_random_response();
        int kind;
        int mode;
        int pos;
        kind = $urandom_range(99);
        add_status_line();
        add_other_headers();
        if (kind < 80)
        begin
            if ($urandom_range(3) == 0)
                add_text("x-ttransfer-encoding: chunked");
            else
                add_mixed_case("transfer-encoding: chunked");
            add_crlf();
            add_other_headers();
            add_crlf();
            add_chunks();
        end
        else
        begin
            add_crlf();
            repeat ($urandom_range(12)) add_byte($urandom_range(255));
        end

        // damage a share of the responses: noise, early end, or one bad byte
        mode = $urandom_range(99);
        if (mode < 8)
        begin
            resp_q.delete();
            repeat ($urandom_range(1, 24)) add_byte($urandom_range(255));
        end
        else if (mode < 20)
        begin
            pos = $urandom_range(resp_q.size() - 1);
            while (resp_q.size() > pos + 1)
                void'(resp_q.pop_back());
        end
        else if (mode < 32)
        begin
            pos = $urandom_range(resp_q.size() - 1);
            if ($urandom_range(1) == 1)
                resp_q[pos] = $urandom_range(255);
            else
                resp_q[pos] = odd_bytes[$urandom_range(3)];
        end
    endtask

    task automatic run_directed();
        // saturating status, extra spaces, upper-case header and hex, trailing bytes
        add_text("HTTP/1.1  12345 OK");
        add_crlf();
        add_text("Transfer-Encoding: CHUNKED");
        add_crlf();
        add_crlf();
        add_text("A");
        add_crlf();
        add_byte(8'h00);
        add_byte(8'hFF);
        repeat (8) add_byte($urandom_range(255));
        add_crlf();
        add_text("0");
        add_crlf();
        add_crlf();
        send_response();

        // plain body, no status
        add_text("x");
        add_crlf();
        add_crlf();
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(CHAR_CR);
        send_response();

        // header never ends
        add_text("HTTP/1.1 200");
        send_response();

        // plain response ending on the header end
        add_text("HTTP/1.1 301");
        add_crlf();
        add_crlf();
        send_response();

        // chunked response ending on the header end
        add_chunked_head();
        send_response();

        // empty length line
        add_chunked_head();
        add_crlf();
        send_response();

        // all-ones length
        add_chunked_head();
        add_text("FFFFFFFF");
        add_crlf();
        add_text("z");
        send_response();
    endtask

    initial
    begin
        int unsigned phase_end;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = send_idle_by_phase[p];
            recv_stall_pct = recv_stall_by_phase[p];
            case (p)
                0:       write_limit('1);
                1:       write_limit($urandom_range(8, 40));
                2:       write_limit($urandom());
                default: write_limit('1);
            endcase
            phase_end = sent_bytes + PHASE_BYTES;
            while (sent_bytes < phase_end)
            begin
                if ($urandom_range(6) == 0)
                    write_limit(random_limit());
                build_random_response();
                send_response();
            end
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/hcrd_pkg.sv
rtl/hcrd_front.sv
rtl/hcrd_queue.sv
rtl/hcrd_core.sv
rtl/http_chunked_response_decoder_unit.sv
rtl/hcrd_checker.sv
sim/hcrd_response_checker.sv
sim/http_chunked_response_decoder_unit_tb.sv
